// File: src/sfd_pkg.sv
// Shared types, constants and the CRC16 byte update for the sync frame deframer.
package sfd_pkg;

    // Default payload buffer size in bytes.
    localparam int PAYLOAD_MAX_DEF = 32;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int LEN_FIELD_W = 6;
    localparam int IDX_FIELD_W = 5;
    localparam int CNT_W32     = 32;
    localparam int TDATA_W     = 128;
    localparam int CFG_IDX_W   = 8;

    // Internal length width covers the largest supported payload size.
    localparam int LEN_W = 7;

    // Descriptor queue depth between the parser and the output side.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

    // Reset values and CRC constants.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0]       CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY        = 16'hA001;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC0 = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CHAN  = 3'd3,
        PH_BODY  = 3'd4,
        PH_CRCLO = 3'd5,
        PH_CRCHI = 3'd6
    } phase_t;

    // Result kinds.
    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_ERR  = 1'b1
    } kind_t;

    // One finished frame as handed from the parser to the output side.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] channel;
        logic [LEN_W-1:0]  len;
        logic [31:0]       good;
        logic [31:0]       bad;
        logic              bank;
    } desc_t;

    // Buffer bank release from the output side back to the parser.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    // CRC16 Modbus update by one byte, reflected, LSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/sync_frame_deframer_crc16.sv
// The first result of a frame follows the taking of its CRC high byte; an error
// report comes out sooner, as it skips the buffer read.
// Throughput: the parser takes one byte a cycle while not stalled; the output side
// starts a payload byte read only once the previous read has loaded the output register.
// The parser stalls only if both buffer banks are still draining or the queue is full.
// Reset: asynchronous, active low; returns to sync hunting with counters at zero.
module sync_frame_deframer_crc16
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // Received bytes.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
    // Results.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] channel, [13:8] frame_len, [45:14] frame_seq, [50:46] byte_index,
    // [58:51] data, [90:59] good_total, [122:91] bad_total, [127:123] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] kind
    output logic                 m_axis_tlast    // last
);

    localparam int IDX_W     = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int RAM_DEPTH = 2 << IDX_W;

    logic              ram_wr_en;
    logic [IDX_W:0]    ram_wr_addr;
    logic [BYTE_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W:0]    ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              push;
    desc_t             push_desc;
    logic              pop;
    desc_t             pop_desc;
    logic              q_empty;
    logic              q_full;
    rel_t              rel;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Parser.
    sfd_front #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_data    (s_axis_tdata),
        .in_ready   (s_axis_tready),
        .ram_wr_en  (ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .push       (push),
        .push_desc  (push_desc),
        .q_full     (q_full),
        .rel        (rel)
    );

    // Two-bank payload buffer.
    sfd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Frame descriptor queue.
    sfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_desc(push_desc),
        .pop      (pop),
        .pop_desc (pop_desc),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Output side.
    sfd_back #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_desc     (pop_desc),
        .pop        (pop),
        .ram_rd_en  (ram_rd_en),
        .ram_rd_addr(ram_rd_addr),
        .ram_rd_data(ram_rd_data),
        .rel        (rel),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

endmodule

// File: src/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sfd_front.sv
// Byte parser: sync hunt, header capture, CRC update, payload buffering.
module sfd_front
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
    localparam int CNT_W = $clog2(PAYLOAD_MAX + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration writes.
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // Received bytes.
    input  logic                 in_valid,
    input  logic [BYTE_W-1:0]    in_data,
    output logic                 in_ready,
    // Payload buffer write port.
    output logic                 ram_wr_en,
    output logic [IDX_W:0]       ram_wr_addr,
    output logic [BYTE_W-1:0]    ram_wr_data,
    // Descriptor queue.
    output logic                 push,
    output desc_t                push_desc,
    input  logic                 q_full,
    // Buffer bank release.
    input  rel_t                 rel
);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] chan_reg, chan_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       crc_upd;
    logic [31:0]       good_reg, good_next;
    logic [31:0]       bad_reg, bad_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [BYTE_W-1:0] sync_first_reg, sync_first_next;
    logic [BYTE_W-1:0] sync_second_reg, sync_second_next;
    logic              acc;

    // Configuration registers.
    always_comb
    begin
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_next  = cfg_data;
                REG_SYNC_SECOND: sync_second_next = cfg_data;
                default:         ;
            endcase
        end
    end

    assign cnt_inc = cnt_reg + 1'b1;
    assign acc     = in_valid & in_ready;

    // Next phase, frame state and outputs.
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        chan_next   = chan_reg;
        crc_lo_next = crc_lo_reg;
        crc_next    = crc_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        bank_next   = bank_reg;
        busy_next   = busy_reg;
        crc_upd     = crc_step(crc_reg, in_data);
        in_ready    = 1'b1;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
        ram_wr_data = in_data;
        push        = 1'b0;
        push_desc   = '{kind: KIND_DATA, channel: chan_reg, len: len_reg,
                        good: good_reg, bad: bad_reg, bank: bank_reg};

        // A bank is free again once its last byte has been read.
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        case (phase_reg)
            PH_SYNC1:
            begin
                if (acc)
                begin
                    phase_next = (in_data == sync_second_reg) ? PH_LEN : PH_SYNC0;
                end
            end
            PH_LEN:
            begin
                if (acc)
                begin
                    if (in_data == '0 || in_data > BYTE_W'(PAYLOAD_MAX))
                    begin
                        phase_next = PH_SYNC0;
                    end
                    else
                    begin
                        len_next   = LEN_W'(in_data);
                        cnt_next   = '0;
                        crc_next   = crc_step(CRC_INIT, in_data);
                        phase_next = PH_CHAN;
                    end
                end
            end
            PH_CHAN:
            begin
                if (acc)
                begin
                    chan_next  = in_data;
                    crc_next   = crc_upd;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                // Wait until the bank is no longer being drained.
                in_ready = ~busy_reg[bank_reg];
                if (acc)
                begin
                    ram_wr_en = 1'b1;
                    cnt_next  = cnt_inc;
                    crc_next  = crc_upd;
                    if (LEN_W'(cnt_inc) >= len_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
            end
            PH_CRCLO:
            begin
                if (acc)
                begin
                    crc_lo_next = in_data;
                    phase_next  = PH_CRCHI;
                end
            end
            PH_CRCHI:
            begin
                // The check result needs a queue slot.
                in_ready = ~q_full;
                if (acc)
                begin
                    push       = 1'b1;
                    phase_next = PH_SYNC0;
                    if ({in_data, crc_lo_reg} == crc_reg)
                    begin
                        good_next           = good_reg + 32'd1;
                        push_desc.good      = good_next;
                        bank_next           = ~bank_reg;
                        busy_next[bank_reg] = 1'b1;
                    end
                    else
                    begin
                        bad_next       = bad_reg + 32'd1;
                        push_desc.kind = KIND_ERR;
                        push_desc.bad  = bad_next;
                    end
                end
            end
            default:
            begin
                if (acc)
                begin
                    phase_next = (in_data == sync_first_reg) ? PH_SYNC1 : PH_SYNC0;
                end
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC0;
            len_reg         <= '0;
            cnt_reg         <= '0;
            chan_reg        <= '0;
            crc_lo_reg      <= '0;
            crc_reg         <= CRC_INIT;
            good_reg        <= '0;
            bad_reg         <= '0;
            bank_reg        <= 1'b0;
            busy_reg        <= '0;
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            len_reg         <= len_next;
            cnt_reg         <= cnt_next;
            chan_reg        <= chan_next;
            crc_lo_reg      <= crc_lo_next;
            crc_reg         <= crc_next;
            good_reg        <= good_next;
            bad_reg         <= bad_next;
            bank_reg        <= bank_next;
            busy_reg        <= busy_next;
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
        end
    end

endmodule

// File: src/sfd_queue.sv
// Short descriptor queue between the parser and the output side.
module sfd_queue
    import sfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t pop_desc,
    output logic  empty,
    output logic  full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    desc_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_desc = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: src/sfd_back.sv
// Output side: drains a good frame from the buffer or sends one error report.
module sfd_back
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    // Descriptor queue.
    input  logic               q_empty,
    input  desc_t              q_desc,
    output logic               pop,
    // Payload buffer read port.
    output logic               ram_rd_en,
    output logic [IDX_W:0]     ram_rd_addr,
    input  logic [BYTE_W-1:0]  ram_rd_data,
    // Bank release to the parser.
    output rel_t               rel,
    // Result stream.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TDATA_W-1:0] m_data,
    output logic               m_user,
    output logic               m_last
);

    desc_t                  cur_reg, cur_next;
    logic                   active_reg, active_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]      out_chan_reg, out_chan_next;
    logic [LEN_FIELD_W-1:0] out_len_reg, out_len_next;
    logic [IDX_FIELD_W-1:0] out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0]      out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic [31:0]            out_good_reg, out_good_next;
    logic [31:0]            out_bad_reg, out_bad_next;
    logic                   issue;
    logic                   last_hit;

    // A step may go ahead when nothing is in flight and the output slot frees up.
    assign issue    = active_reg & ~pend_reg & (~out_valid_reg | m_ready);
    assign last_hit = (LEN_W'(idx_reg) + LEN_W'(1)) == cur_reg.len;

    // Sequencing of reads and result loading.
    always_comb
    begin
        cur_next       = cur_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        out_kind_next  = out_kind_reg;
        out_chan_next  = out_chan_reg;
        out_len_next   = out_len_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_good_next  = out_good_reg;
        out_bad_next   = out_bad_reg;
        pop            = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = {cur_reg.bank, idx_reg};
        rel            = '{valid: 1'b0, bank: cur_reg.bank};

        // Take the next frame when idle.
        if (!active_reg && !q_empty)
        begin
            pop         = 1'b1;
            cur_next    = q_desc;
            active_next = 1'b1;
            idx_next    = '0;
        end

        if (issue)
        begin
            if (cur_reg.kind == KIND_ERR)
            begin
                // Error report goes straight to the output register.
                out_valid_next = 1'b1;
                out_kind_next  = KIND_ERR;
                out_chan_next  = cur_reg.channel;
                out_len_next   = LEN_FIELD_W'(cur_reg.len);
                out_idx_next   = '0;
                out_data_next  = '0;
                out_last_next  = 1'b1;
                out_good_next  = cur_reg.good;
                out_bad_next   = cur_reg.bad;
                active_next    = 1'b0;
            end
            else
            begin
                // Read one payload byte; the last read frees the bank.
                ram_rd_en      = 1'b1;
                pend_next      = 1'b1;
                pend_idx_next  = idx_reg;
                pend_last_next = last_hit;
                idx_next       = idx_reg + 1'b1;
                if (last_hit)
                begin
                    active_next = 1'b0;
                    rel.valid   = 1'b1;
                end
            end
        end

        // Read data arrives: load the output register.
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_DATA;
            out_chan_next  = cur_reg.channel;
            out_len_next   = LEN_FIELD_W'(cur_reg.len);
            out_idx_next   = IDX_FIELD_W'(pend_idx_reg);
            out_data_next  = ram_rd_data;
            out_last_next  = pend_last_reg;
            out_good_next  = cur_reg.good;
            out_bad_next   = cur_reg.bad;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_kind_reg  <= out_kind_next;
        out_chan_reg  <= out_chan_next;
        out_len_reg   <= out_len_next;
        out_idx_reg   <= out_idx_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_good_reg  <= out_good_next;
        out_bad_reg   <= out_bad_next;
    end

    // Result packing; frame_seq equals the good frame count.
    assign m_valid = out_valid_reg;
    assign m_user  = out_kind_reg;
    assign m_last  = out_last_reg;
    assign m_data  = {5'b0, out_bad_reg, out_good_reg, out_data_reg, out_idx_reg,
                      out_good_reg, out_len_reg, out_chan_reg};

endmodule

// File: src/sfd_checker.sv
// Port-level checks on the deframer result stream, bound to the top level.
module sfd_checker
    import sfd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    // No result is offered while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // A stalled result holds its data until the transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An error report is a run of one with zero index and data.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[58:46] == 13'd0)
        else $error("malformed error report");

    // The sequence number always tracks the good frame count.
    a_seq_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[45:14] == m_axis_tdata[90:59])
        else $error("sequence number differs from good count");

endmodule

bind sync_frame_deframer_crc16 sfd_checker u_sfd_checker (.*);
